// ===== rtl/core/biot_savart_segment_velocity_assert.svh =====
// Assertion macros used by the checker file bsv_checker.sv.
`ifndef BIOT_SAVART_SEGMENT_VELOCITY_ASSERT_SVH
`define BIOT_SAVART_SEGMENT_VELOCITY_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsv check failed");

// Next-cycle implication, active through reset.
`define BSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bsv check failed");

`endif

// ===== rtl/core/bsv_pkg.sv =====
package bsv_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int RW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * RW;
  localparam int CW  = PW + 1;
  localparam int SW  = PW + 2;
  localparam int MW  = PW;
  localparam int HW  = MW / 2;
  localparam int XW  = 2 * MW;
  localparam int QW  = MW + 2 * FRAC_BITS;
  localparam int RTW = QW / 2;
  localparam int RMW = RTW + 2;
  localparam int TW  = RTW + 1;
  localparam int GW  = RTW + 2;
  localparam int VMW = XW + FRAC_BITS;
  localparam int VCW = VMW + COORD_WIDTH;

  localparam int FRONT_LAT = 4;
  localparam int MUL_LAT   = 2;
  localparam int PROJ_LAT  = QW + RTW;
  localparam int VDIV_LAT  = COORD_WIDTH + 1;
  localparam int G_STAGE   = FRONT_LAT + MUL_LAT + PROJ_LAT + 2;
  localparam int LATENCY   = G_STAGE + MUL_LAT + VDIV_LAT + 1;
  localparam int CLINE_LEN = G_STAGE - FRONT_LAT;
  localparam int DLINE_LEN = G_STAGE - 5;
  localparam int FLAG_LEN  = LATENCY - 5;

  localparam int NXA [3] = '{1, 2, 0};
  localparam int NXB [3] = '{2, 0, 1};

  localparam logic [COORD_WIDTH-1:0] VEL_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] VEL_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic           neg;
    logic [RTW-1:0] root;
  } proj_t;

  typedef struct packed {
    logic                   big;
    logic                   neg;
    logic [COORD_WIDTH-1:0] q;
  } vdiv_t;

  typedef struct packed {
    logic [2:0]          neg;
    logic [2:0][MW-1:0]  mag;
  } cside_t;

endpackage

// ===== rtl/core/bsv_mul.sv =====
module bsv_mul (
  input  logic                      clk,
  input  logic [bsv_pkg::MW-1:0]    a,
  input  logic [bsv_pkg::MW-1:0]    b,
  output logic [bsv_pkg::XW-1:0]    p
);

  logic [2*bsv_pkg::HW-1:0] pp00, pp01, pp10, pp11;

  always_ff @(posedge clk) begin
    pp00 <= a[bsv_pkg::HW-1:0] * b[bsv_pkg::HW-1:0];
    pp01 <= a[bsv_pkg::HW-1:0] * b[bsv_pkg::MW-1:bsv_pkg::HW];
    pp10 <= a[bsv_pkg::MW-1:bsv_pkg::HW] * b[bsv_pkg::HW-1:0];
    pp11 <= a[bsv_pkg::MW-1:bsv_pkg::HW] * b[bsv_pkg::MW-1:bsv_pkg::HW];
    p    <= bsv_pkg::XW'(pp00)
          + (bsv_pkg::XW'(pp01) << bsv_pkg::HW)
          + (bsv_pkg::XW'(pp10) << bsv_pkg::HW)
          + (bsv_pkg::XW'(pp11) << (2 * bsv_pkg::HW));
  end

endmodule

// ===== rtl/core/bsv_proj.sv =====
module bsv_proj (
  input  logic                      clk,
  input  logic [bsv_pkg::XW-1:0]    dsq,
  input  logic [bsv_pkg::MW-1:0]    sq,
  input  logic                      neg,
  output bsv_pkg::proj_t            res
);

  // restoring divide, one quotient bit per stage
  logic [bsv_pkg::MW-1:0]  drem [bsv_pkg::QW];
  logic [bsv_pkg::QW-1:0]  dwrd [bsv_pkg::QW];
  logic [bsv_pkg::MW-1:0]  ddvs [bsv_pkg::QW];
  logic                    dneg [bsv_pkg::QW];
  logic [bsv_pkg::MW-1:0]  prem [bsv_pkg::QW];
  logic [bsv_pkg::QW-1:0]  pwrd [bsv_pkg::QW];
  logic [bsv_pkg::MW-1:0]  pdvs [bsv_pkg::QW];
  logic                    pneg [bsv_pkg::QW];
  logic [bsv_pkg::MW:0]    dtry [bsv_pkg::QW];
  logic [bsv_pkg::MW+1:0]  ddif [bsv_pkg::QW];

  // digit-by-digit square root, one root bit per stage
  logic [bsv_pkg::RMW-1:0] srem [bsv_pkg::RTW];
  logic [bsv_pkg::RTW-1:0] sroot [bsv_pkg::RTW];
  logic [bsv_pkg::QW-1:0]  sx [bsv_pkg::RTW];
  logic                    sneg [bsv_pkg::RTW];
  logic [bsv_pkg::RMW-1:0] qrem [bsv_pkg::RTW];
  logic [bsv_pkg::RTW-1:0] qroot [bsv_pkg::RTW];
  logic [bsv_pkg::QW-1:0]  qx [bsv_pkg::RTW];
  logic                    qneg [bsv_pkg::RTW];
  logic [bsv_pkg::RMW+1:0] srs [bsv_pkg::RTW];
  logic [bsv_pkg::RMW+2:0] sdif [bsv_pkg::RTW];

  always_comb begin
    prem[0] = dsq[bsv_pkg::XW-1:bsv_pkg::MW];
    pwrd[0] = {dsq[bsv_pkg::MW-1:0], {(2*bsv_pkg::FRAC_BITS){1'b0}}};
    pdvs[0] = sq;
    pneg[0] = neg;
    for (int i = 1; i < bsv_pkg::QW; i++) begin
      prem[i] = drem[i-1];
      pwrd[i] = dwrd[i-1];
      pdvs[i] = ddvs[i-1];
      pneg[i] = dneg[i-1];
    end
    for (int i = 0; i < bsv_pkg::QW; i++) begin
      dtry[i] = {prem[i], pwrd[i][bsv_pkg::QW-1]};
      ddif[i] = {1'b0, dtry[i]} - {2'b00, pdvs[i]};
    end

    qrem[0]  = '0;
    qroot[0] = '0;
    qx[0]    = dwrd[bsv_pkg::QW-1];
    qneg[0]  = dneg[bsv_pkg::QW-1];
    for (int j = 1; j < bsv_pkg::RTW; j++) begin
      qrem[j]  = srem[j-1];
      qroot[j] = sroot[j-1];
      qx[j]    = sx[j-1];
      qneg[j]  = sneg[j-1];
    end
    for (int j = 0; j < bsv_pkg::RTW; j++) begin
      srs[j]  = {qrem[j], qx[j][bsv_pkg::QW-1:bsv_pkg::QW-2]};
      sdif[j] = {1'b0, srs[j]} - (bsv_pkg::RMW+3)'({qroot[j], 2'b01});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < bsv_pkg::QW; i++) begin
      if (!ddif[i][bsv_pkg::MW+1]) begin
        drem[i] <= ddif[i][bsv_pkg::MW-1:0];
        dwrd[i] <= {pwrd[i][bsv_pkg::QW-2:0], 1'b1};
      end else begin
        drem[i] <= dtry[i][bsv_pkg::MW-1:0];
        dwrd[i] <= {pwrd[i][bsv_pkg::QW-2:0], 1'b0};
      end
      ddvs[i] <= pdvs[i];
      dneg[i] <= pneg[i];
    end
    for (int j = 0; j < bsv_pkg::RTW; j++) begin
      if (!sdif[j][bsv_pkg::RMW+2]) begin
        srem[j]  <= sdif[j][bsv_pkg::RMW-1:0];
        sroot[j] <= {qroot[j][bsv_pkg::RTW-2:0], 1'b1};
      end else begin
        srem[j]  <= srs[j][bsv_pkg::RMW-1:0];
        sroot[j] <= {qroot[j][bsv_pkg::RTW-2:0], 1'b0};
      end
      sx[j]   <= {qx[j][bsv_pkg::QW-3:0], 2'b00};
      sneg[j] <= qneg[j];
    end
  end

  assign res.root = sroot[bsv_pkg::RTW-1];
  assign res.neg  = sneg[bsv_pkg::RTW-1];

endmodule

// ===== rtl/core/bsv_vdiv.sv =====
module bsv_vdiv (
  input  logic                      clk,
  input  logic [bsv_pkg::XW-1:0]    prod,
  input  logic [bsv_pkg::XW-1:0]    dvs,
  input  logic                      neg,
  output bsv_pkg::vdiv_t            res
);

  logic [bsv_pkg::VMW-1:0]          m;
  logic                             big0;
  logic [bsv_pkg::XW-1:0]           rem0;
  logic [bsv_pkg::COORD_WIDTH-1:0]  wrd0;
  logic [bsv_pkg::XW-1:0]           dvs0;
  logic                             neg0;

  logic [bsv_pkg::XW-1:0]           vrem [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::COORD_WIDTH-1:0]  vwrd [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::XW-1:0]           vdvs [bsv_pkg::COORD_WIDTH];
  logic                             vneg [bsv_pkg::COORD_WIDTH];
  logic                             vbig [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::XW-1:0]           prem [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::COORD_WIDTH-1:0]  pwrd [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::XW-1:0]           pdvs [bsv_pkg::COORD_WIDTH];
  logic                             pneg [bsv_pkg::COORD_WIDTH];
  logic                             pbig [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::XW:0]             vtry [bsv_pkg::COORD_WIDTH];
  logic [bsv_pkg::XW+1:0]           vdif [bsv_pkg::COORD_WIDTH];

  assign m = {prod, {bsv_pkg::FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    big0 <= bsv_pkg::VCW'(m) >= bsv_pkg::VCW'({dvs, {bsv_pkg::COORD_WIDTH{1'b0}}});
    rem0 <= bsv_pkg::XW'(m >> bsv_pkg::COORD_WIDTH);
    wrd0 <= m[bsv_pkg::COORD_WIDTH-1:0];
    dvs0 <= dvs;
    neg0 <= neg;
  end

  always_comb begin
    prem[0] = rem0;
    pwrd[0] = wrd0;
    pdvs[0] = dvs0;
    pneg[0] = neg0;
    pbig[0] = big0;
    for (int i = 1; i < bsv_pkg::COORD_WIDTH; i++) begin
      prem[i] = vrem[i-1];
      pwrd[i] = vwrd[i-1];
      pdvs[i] = vdvs[i-1];
      pneg[i] = vneg[i-1];
      pbig[i] = vbig[i-1];
    end
    for (int i = 0; i < bsv_pkg::COORD_WIDTH; i++) begin
      vtry[i] = {prem[i], pwrd[i][bsv_pkg::COORD_WIDTH-1]};
      vdif[i] = {1'b0, vtry[i]} - {2'b00, pdvs[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < bsv_pkg::COORD_WIDTH; i++) begin
      if (!vdif[i][bsv_pkg::XW+1]) begin
        vrem[i] <= vdif[i][bsv_pkg::XW-1:0];
        vwrd[i] <= {pwrd[i][bsv_pkg::COORD_WIDTH-2:0], 1'b1};
      end else begin
        vrem[i] <= vtry[i][bsv_pkg::XW-1:0];
        vwrd[i] <= {pwrd[i][bsv_pkg::COORD_WIDTH-2:0], 1'b0};
      end
      vdvs[i] <= pdvs[i];
      vneg[i] <= pneg[i];
      vbig[i] <= pbig[i];
    end
  end

  assign res.q   = vwrd[bsv_pkg::COORD_WIDTH-1];
  assign res.neg = vneg[bsv_pkg::COORD_WIDTH-1];
  assign res.big = vbig[bsv_pkg::COORD_WIDTH-1];

endmodule

// ===== rtl/core/biot_savart_segment_velocity.sv =====
// Straight vortex segment kernel: velocity induced at a point by a unit
// strength segment, signed Q16.16 in and out.
// Input: drive the nine coordinates and raise start; a beat is taken at
// each rising edge with start high and busy low. busy is high only while
// rst is high, so one beat per clock is taken in normal operation.
// Output: done pulses for one cycle with vel_x/y/z and status; the
// receiver cannot stall and none is needed, since nothing waits inside.
// The pipeline has four front stages, two wide multiplies, a 98-stage divide
// plus 49-stage root for each projection term, and a 33-stage divide per
// velocity component.
// Throughput is one beat per cycle at any input pattern.
// status: 0 ok, 1 degenerate geometry (outputs zero), 2 saturated.
// Reset (synchronous) clears the valid pipeline; beats in flight are dropped.
module biot_savart_segment_velocity (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  point_x,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  point_y,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  point_z,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  start_x,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  start_y,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  start_z,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  end_x,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  end_y,
  input  logic signed [bsv_pkg::COORD_WIDTH-1:0]  end_z,
  output logic                                    done,
  output logic signed [bsv_pkg::COORD_WIDTH-1:0]  vel_x,
  output logic signed [bsv_pkg::COORD_WIDTH-1:0]  vel_y,
  output logic signed [bsv_pkg::COORD_WIDTH-1:0]  vel_z,
  output logic [1:0]                              status
);

  logic                                   acc;
  logic [bsv_pkg::LATENCY-1:0]            vld;

  logic signed [bsv_pkg::COORD_WIDTH-1:0] pt [3];
  logic signed [bsv_pkg::COORD_WIDTH-1:0] st [3];
  logic signed [bsv_pkg::COORD_WIDTH-1:0] en [3];

  logic signed [bsv_pkg::RW-1:0]          r0 [3];
  logic signed [bsv_pkg::RW-1:0]          r1 [3];
  logic signed [bsv_pkg::RW-1:0]          r2 [3];

  logic signed [bsv_pkg::PW-1:0]          pc [3];
  logic signed [bsv_pkg::PW-1:0]          qc [3];
  logic signed [bsv_pkg::PW-1:0]          pd1 [3];
  logic signed [bsv_pkg::PW-1:0]          ps1 [3];
  logic signed [bsv_pkg::PW-1:0]          pd2 [3];
  logic signed [bsv_pkg::PW-1:0]          ps2 [3];

  logic signed [bsv_pkg::CW-1:0]          cr [3];
  logic signed [bsv_pkg::SW-1:0]          dot1, dot2, sum1, sum2;

  bsv_pkg::cside_t                        cs4;
  logic                                   degen4;
  logic [bsv_pkg::MW-1:0]                 dmag1, dmag2, sqm1, sqm2;
  logic                                   dneg1, dneg2;

  logic [bsv_pkg::MW-1:0]                 sq1a, sq1b, sq2a, sq2b;
  logic                                   dn1a, dn1b, dn2a, dn2b;

  logic [bsv_pkg::XW-1:0]                 csq [3];
  logic [bsv_pkg::XW-1:0]                 dsq1, dsq2;
  logic [bsv_pkg::XW-1:0]                 dsum;

  bsv_pkg::proj_t                         pr1, pr2;
  logic signed [bsv_pkg::TW-1:0]          t1, t2;
  logic signed [bsv_pkg::GW-1:0]          g;
  logic [bsv_pkg::MW-1:0]                 gmag;
  logic                                   gneg;

  bsv_pkg::cside_t                        cline [bsv_pkg::CLINE_LEN];
  logic [bsv_pkg::XW-1:0]                 dline [bsv_pkg::DLINE_LEN];
  logic [bsv_pkg::FLAG_LEN-1:0]           fline;

  logic [bsv_pkg::XW-1:0]                 vprod [3];
  logic [2:0]                             vn1, vn2;
  bsv_pkg::vdiv_t                         vq [3];

  logic [bsv_pkg::COORD_WIDTH-1:0]        vel_next [3];
  logic [2:0]                             sat;
  bsv_pkg::status_t                       status_next;

  assign busy = rst;
  assign acc  = start && !busy;
  assign done = vld[bsv_pkg::LATENCY-1];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;
  assign st[0] = start_x;
  assign st[1] = start_y;
  assign st[2] = start_z;
  assign en[0] = end_x;
  assign en[1] = end_y;
  assign en[2] = end_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[bsv_pkg::LATENCY-2:0], acc};
    end
  end

  // front end: differences, products, sums, magnitudes
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      r0[k] <= bsv_pkg::RW'(en[k]) - bsv_pkg::RW'(st[k]);
      r1[k] <= bsv_pkg::RW'(pt[k]) - bsv_pkg::RW'(st[k]);
      r2[k] <= bsv_pkg::RW'(pt[k]) - bsv_pkg::RW'(en[k]);
    end
    for (int k = 0; k < 3; k++) begin
      pc[k]  <= r0[bsv_pkg::NXA[k]] * r1[bsv_pkg::NXB[k]];
      qc[k]  <= r0[bsv_pkg::NXB[k]] * r1[bsv_pkg::NXA[k]];
      pd1[k] <= r0[k] * r1[k];
      ps1[k] <= r1[k] * r1[k];
      pd2[k] <= r0[k] * r2[k];
      ps2[k] <= r2[k] * r2[k];
    end
    for (int k = 0; k < 3; k++) begin
      cr[k] <= bsv_pkg::CW'(pc[k]) - bsv_pkg::CW'(qc[k]);
    end
    dot1 <= bsv_pkg::SW'(pd1[0]) + bsv_pkg::SW'(pd1[1]) + bsv_pkg::SW'(pd1[2]);
    sum1 <= bsv_pkg::SW'(ps1[0]) + bsv_pkg::SW'(ps1[1]) + bsv_pkg::SW'(ps1[2]);
    dot2 <= bsv_pkg::SW'(pd2[0]) + bsv_pkg::SW'(pd2[1]) + bsv_pkg::SW'(pd2[2]);
    sum2 <= bsv_pkg::SW'(ps2[0]) + bsv_pkg::SW'(ps2[1]) + bsv_pkg::SW'(ps2[2]);
    for (int k = 0; k < 3; k++) begin
      cs4.neg[k] <= cr[k][bsv_pkg::CW-1];
      cs4.mag[k] <= bsv_pkg::MW'(cr[k][bsv_pkg::CW-1] ? -cr[k] : cr[k]);
    end
    degen4 <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    dneg1  <= dot1[bsv_pkg::SW-1];
    dneg2  <= dot2[bsv_pkg::SW-1];
    dmag1  <= bsv_pkg::MW'(dot1[bsv_pkg::SW-1] ? -dot1 : dot1);
    dmag2  <= bsv_pkg::MW'(dot2[bsv_pkg::SW-1] ? -dot2 : dot2);
    sqm1   <= bsv_pkg::MW'(sum1);
    sqm2   <= bsv_pkg::MW'(sum2);
    sq1a   <= sqm1;
    sq1b   <= sq1a;
    sq2a   <= sqm2;
    sq2b   <= sq2a;
    dn1a   <= dneg1;
    dn1b   <= dn1a;
    dn2a   <= dneg2;
    dn2b   <= dn2a;
    dsum   <= csq[0] + csq[1] + csq[2];
  end

  for (genvar k = 0; k < 3; k++) begin : g_csq
    bsv_mul u_csq (
      .clk (clk),
      .a   (cs4.mag[k]),
      .b   (cs4.mag[k]),
      .p   (csq[k])
    );
  end

  bsv_mul u_dsq1 (.clk(clk), .a(dmag1), .b(dmag1), .p(dsq1));
  bsv_mul u_dsq2 (.clk(clk), .a(dmag2), .b(dmag2), .p(dsq2));

  bsv_proj u_proj1 (.clk(clk), .dsq(dsq1), .sq(sq1b), .neg(dn1b), .res(pr1));
  bsv_proj u_proj2 (.clk(clk), .dsq(dsq2), .sq(sq2b), .neg(dn2b), .res(pr2));

  always_comb begin
    t1 = $signed({1'b0, pr1.root});
    t2 = $signed({1'b0, pr2.root});
    if (pr1.neg) begin
      t1 = -t1;
    end
    if (pr2.neg) begin
      t2 = -t2;
    end
  end

  always_ff @(posedge clk) begin
    g    <= bsv_pkg::GW'(t2) - bsv_pkg::GW'(t1);
    gneg <= g[bsv_pkg::GW-1];
    gmag <= bsv_pkg::MW'(g[bsv_pkg::GW-1] ? -g : g);
  end

  always_ff @(posedge clk) begin
    cline[0] <= cs4;
    for (int i = 1; i < bsv_pkg::CLINE_LEN; i++) begin
      cline[i] <= cline[i-1];
    end
    dline[0] <= dsum;
    for (int i = 1; i < bsv_pkg::DLINE_LEN; i++) begin
      dline[i] <= dline[i-1];
    end
    fline <= {fline[bsv_pkg::FLAG_LEN-2:0], degen4};
    vn1   <= cline[bsv_pkg::CLINE_LEN-1].neg ^ {3{gneg}};
    vn2   <= vn1;
  end

  for (genvar k = 0; k < 3; k++) begin : g_vel
    bsv_mul u_vmul (
      .clk (clk),
      .a   (cline[bsv_pkg::CLINE_LEN-1].mag[k]),
      .b   (gmag),
      .p   (vprod[k])
    );
    bsv_vdiv u_vdiv (
      .clk  (clk),
      .prod (vprod[k]),
      .dvs  (dline[bsv_pkg::DLINE_LEN-1]),
      .neg  (vn2[k]),
      .res  (vq[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (vq[k].neg) begin
        sat[k] = vq[k].big
               || (vq[k].q[bsv_pkg::COORD_WIDTH-1] && (vq[k].q[bsv_pkg::COORD_WIDTH-2:0] != '0));
        vel_next[k] = sat[k] ? bsv_pkg::VEL_MIN : -vq[k].q;
      end else begin
        sat[k] = vq[k].big || vq[k].q[bsv_pkg::COORD_WIDTH-1];
        vel_next[k] = sat[k] ? bsv_pkg::VEL_MAX : vq[k].q;
      end
    end
    if (fline[bsv_pkg::FLAG_LEN-1]) begin
      for (int k = 0; k < 3; k++) begin
        vel_next[k] = '0;
      end
      status_next = bsv_pkg::ST_DEGEN;
    end else if (sat != 3'b000) begin
      status_next = bsv_pkg::ST_SAT;
    end else begin
      status_next = bsv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    vel_x  <= vel_next[0];
    vel_y  <= vel_next[1];
    vel_z  <= vel_next[2];
    status <= status_next;
  end

endmodule

// ===== rtl/core/bsv_checker.sv =====
`include "biot_savart_segment_velocity_assert.svh"

module bsv_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    start,
  input logic                                    busy,
  input logic                                    done,
  input logic signed [bsv_pkg::COORD_WIDTH-1:0]  vel_x,
  input logic signed [bsv_pkg::COORD_WIDTH-1:0]  vel_y,
  input logic signed [bsv_pkg::COORD_WIDTH-1:0]  vel_z,
  input logic [1:0]                              status
);

  `BSV_ASSERT_IMP(a_degen_zero, done && status == bsv_pkg::ST_DEGEN, vel_x == '0 && vel_y == '0 && vel_z == '0)
  `BSV_ASSERT_IMP(a_status_code, done, status == bsv_pkg::ST_OK || status == bsv_pkg::ST_DEGEN || status == bsv_pkg::ST_SAT)
  `BSV_ASSERT_IMP(a_sat_rail, done && status == bsv_pkg::ST_SAT, vel_x == bsv_pkg::VEL_MAX || vel_x == bsv_pkg::VEL_MIN || vel_y == bsv_pkg::VEL_MAX || vel_y == bsv_pkg::VEL_MIN || vel_z == bsv_pkg::VEL_MAX || vel_z == bsv_pkg::VEL_MIN)
  `BSV_ASSERT_IMP(a_latency, done, $past(start && !busy, bsv_pkg::LATENCY))
  `BSV_ASSERT_NXT(a_reset_quiet, rst, !done)

endmodule

bind biot_savart_segment_velocity bsv_checker u_bsv_checker (.*);

// ===== tb/biot_savart_segment_velocity_tb.sv =====
`timescale 1ns / 100ps

module biot_savart_segment_velocity_tb;
  import bsv_pkg::*;

  localparam int CW_IN   = COORD_WIDTH;
  localparam int N_RAND  = 680;
  localparam int N_DIR   = 16;
  localparam int LIMIT   = 400000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW_IN-1:0] coord_t;

  typedef struct {
    coord_t p[3];
    coord_t s[3];
    coord_t e[3];
  } seg_beat_t;

  typedef struct {
    coord_t  v[3];
    status_t st;
  } vel_beat_t;

  typedef struct {
    seg_beat_t b;
    bit        typed;
    vel_beat_t want;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  coord_t start_x = '0, start_y = '0, start_z = '0;
  coord_t end_x = '0, end_y = '0, end_z = '0;
  coord_t vel_x, vel_y, vel_z;
  logic [1:0] status;

  biot_savart_segment_velocity dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .done(done), .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vel_beat_t vel_q[$];
  seg_row_t  dir_rows[N_DIR];
  int        n_acc = 0;
  int        n_done = 0;
  int        n_degen = 0;
  int        n_sat = 0;
  int        errors = 0;
  int        cycles = 0;
  int        idle_pct = 0;

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wide_t proj_term(wide_t dot, wide_t sq);
    wide_t m, q, r, t;
    m = wabs(dot);
    q = (m * m <<< (2 * FRAC_BITS)) / sq;
    r = 0;
    for (int i = 90; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= q) r = t;
    end
    return (dot < 0) ? -r : r;
  endfunction

  function automatic vel_beat_t seg_velocity(seg_beat_t b);
    wide_t r0[3], r1[3], r2[3], c[3];
    wide_t d, dot1, sq1, dot2, sq2, g, p, q, lim;
    vel_beat_t o;
    bit sat, neg;
    int i, j;
    for (int k = 0; k < 3; k++) begin
      r0[k] = wide_t'(b.e[k]) - wide_t'(b.s[k]);
      r1[k] = wide_t'(b.p[k]) - wide_t'(b.s[k]);
      r2[k] = wide_t'(b.p[k]) - wide_t'(b.e[k]);
    end
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      c[k] = r0[i] * r1[j] - r0[j] * r1[i];
    end
    d = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    if (d == 0) begin
      o.v = '{default: '0};
      o.st = ST_DEGEN;
      return o;
    end
    dot1 = r0[0] * r1[0] + r0[1] * r1[1] + r0[2] * r1[2];
    sq1  = r1[0] * r1[0] + r1[1] * r1[1] + r1[2] * r1[2];
    dot2 = r0[0] * r2[0] + r0[1] * r2[1] + r0[2] * r2[2];
    sq2  = r2[0] * r2[0] + r2[1] * r2[1] + r2[2] * r2[2];
    g = proj_term(dot2, sq2) - proj_term(dot1, sq1);
    lim = wide_t'(1) <<< (CW_IN - 1);
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p = c[k] * g;
      neg = (p < 0);
      q = (wabs(p) <<< FRAC_BITS) / d;
      if (!neg && q >= lim) begin
        q = lim - 1;
        sat = 1'b1;
      end else if (neg && q > lim) begin
        q = lim;
        sat = 1'b1;
      end
      if (neg) q = -q;
      o.v[k] = q[CW_IN-1:0];
    end
    o.st = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  function automatic coord_t rnd_small(int span);
    return coord_t'($signed($urandom_range(0, 2 * span))) - coord_t'(span);
  endfunction

  function automatic seg_beat_t rand_beat();
    seg_beat_t b;
    coord_t dir[3];
    int kind, kk;
    kind = $urandom_range(0, 99);
    kk = $urandom_range(0, 7) - 3;
    for (int k = 0; k < 3; k++) begin
      if (kind < 20) begin
        b.p[k] = $urandom;
        b.s[k] = $urandom;
        b.e[k] = $urandom;
      end else if (kind < 35) begin
        b.s[k] = rnd_small(1 << 20);
        dir[k] = rnd_small(1 << 12);
        b.e[k] = b.s[k] + dir[k];
        b.p[k] = b.s[k] + dir[k] * kk;
      end else if (kind < 50) begin
        b.s[k] = rnd_small(1 << 18);
        b.e[k] = b.s[k] + rnd_small(1 << 18);
        b.p[k] = b.s[k] + rnd_small(8);
      end else begin
        b.p[k] = rnd_small(1 << 21);
        b.s[k] = rnd_small(1 << 21);
        b.e[k] = rnd_small(1 << 21);
      end
    end
    return b;
  endfunction

  task automatic set_row(int idx, coord_t px, coord_t py, coord_t pz, coord_t sx,
                         coord_t sy, coord_t sz, coord_t ex, coord_t ey, coord_t ez,
                         bit typed, status_t st);
    dir_rows[idx].b.p = '{px, py, pz};
    dir_rows[idx].b.s = '{sx, sy, sz};
    dir_rows[idx].b.e = '{ex, ey, ez};
    dir_rows[idx].typed = typed;
    dir_rows[idx].want.v = '{default: '0};
    dir_rows[idx].want.st = st;
  endtask

  task automatic send_beat(seg_beat_t b);
    int target;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    {point_x, point_y, point_z} <= {b.p[0], b.p[1], b.p[2]};
    {start_x, start_y, start_z} <= {b.s[0], b.s[1], b.s[2]};
    {end_x, end_y, end_z} <= {b.e[0], b.e[1], b.e[2]};
    start <= 1'b1;
    target = n_acc + 1;
    do @(negedge clk); while (n_acc < target);
  endtask

  always @(posedge clk) begin
    seg_beat_t b;
    if (!rst && start && !busy) begin
      b.p = '{point_x, point_y, point_z};
      b.s = '{start_x, start_y, start_z};
      b.e = '{end_x, end_y, end_z};
      vel_q.push_back(seg_velocity(b));
      n_acc <= n_acc + 1;
    end
  end

  always @(posedge clk) begin
    vel_beat_t w;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && done) begin
      n_done <= n_done + 1;
      if (vel_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors <= errors + 1;
      end else begin
        w = vel_q.pop_front();
        if (w.st == ST_DEGEN) n_degen <= n_degen + 1;
        if (w.st == ST_SAT) n_sat <= n_sat + 1;
        if (vel_x !== w.v[0] || vel_y !== w.v[1] || vel_z !== w.v[2] ||
            status !== w.st) begin
          $display("%0t: mismatch exp %h %h %h st %0d, got %h %h %h st %0d", $time,
                   w.v[0], w.v[1], w.v[2], w.st, vel_x, vel_y, vel_z, status);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    coord_t mx, mn;
    vel_beat_t chk;
    mx = VEL_MAX;
    mn = VEL_MIN;
    set_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_DEGEN);
    set_row(1, 5, 7, 9, 5, 7, 9, 100, 3, 2, 1, ST_DEGEN);
    set_row(2, 1, 2, 3, 40, 50, 60, 40, 50, 60, 1, ST_DEGEN);
    set_row(3, mx, mx, mx, mn, mn, mn, mx, mx, mx, 1, ST_DEGEN);
    set_row(4, 300, 300, 300, 100, 100, 100, 200, 200, 200, 1, ST_DEGEN);
    set_row(5, mn, mn, mn, mn, mn, mn, mn, mn, mn, 1, ST_DEGEN);
    set_row(6, mx, mn, 0, mn, mx, mx, mx, mx, mn, 0, ST_OK);
    set_row(7, mn, mx, mn, mx, mn, mn, mn, mn, mx, 0, ST_OK);
    set_row(8, 32768, 1, 0, 0, 0, 0, 65536, 0, 0, 0, ST_OK);
    set_row(9, 32768, -1, 0, 0, 0, 0, 65536, 0, 0, 0, ST_OK);
    set_row(10, 0, 65536, 0, 0, 0, 0, 65536, 0, 0, 0, ST_OK);
    set_row(11, 0, 0, 65536, -65536, 0, 0, 65536, 0, 0, 0, ST_OK);
    set_row(12, mx, mx, mx, 0, 0, 0, -1, 1, -1, 0, ST_OK);
    set_row(13, 1, 1, 1, mx, mn, mx, mn, mx, mn, 0, ST_OK);
    set_row(14, -1, -1, -1, 0, 0, 0, 1, 0, 0, 0, ST_OK);
    set_row(15, 10, 0, 1, 0, 0, 0, 1, 0, 0, 0, ST_OK);
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].typed) begin
        chk = seg_velocity(dir_rows[i].b);
        if (chk.st != dir_rows[i].want.st) begin
          $display("%0t: table row %0d disagrees with predictor", $time, i);
          errors++;
        end
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < N_DIR; i++) send_beat(dir_rows[i].b);

    for (int i = 0; i < N_RAND; i++) begin
      if (i < N_RAND / 3) idle_pct = 26;
      else if (i < 2 * N_RAND / 3) idle_pct = 47;
      else idle_pct = 0;
      if (i == N_RAND / 3) begin
        start <= 1'b0;
        while (vel_q.size() != 0) @(negedge clk);
      end
      send_beat(rand_beat());
    end
    start <= 1'b0;

    while (vel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("tb: %0d beats sent (%0d directed), %0d results checked", n_acc, N_DIR, n_done);
    $display("tb: %0d degenerate and %0d saturated results seen", n_degen, n_sat);
    if (errors == 0 && vel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bsv_pkg.sv
rtl/core/bsv_mul.sv
rtl/core/bsv_proj.sv
rtl/core/bsv_vdiv.sv
rtl/core/biot_savart_segment_velocity.sv
rtl/core/bsv_checker.sv
tb/biot_savart_segment_velocity_tb.sv
